>>> rtl/slm_pkg.sv
// shared types, constants and slot lookup for the syscall latency monitor
package slm_pkg;

   localparam int THREAD_ENTRIES_DEF = 16384;
   localparam int GROUP_COUNT_DEF    = 256;
   localparam int SLOT_COUNT         = 17;

   localparam int TIDX_W   = 14;
   localparam int NR_W     = 10;
   localparam int GROUP_W  = 8;
   localparam int SLOT_W   = 5;
   localparam int STATUS_W = 3;
   localparam int DATA_W   = 64;

   localparam logic [STATUS_W-1:0] STATUS_STORED    = 3'd0;
   localparam logic [STATUS_W-1:0] STATUS_UNTRACKED = 3'd1;
   localparam logic [STATUS_W-1:0] STATUS_NO_ENTRY  = 3'd2;
   localparam logic [STATUS_W-1:0] STATUS_NEGATIVE  = 3'd3;
   localparam logic [STATUS_W-1:0] STATUS_UPDATED   = 3'd4;

   localparam logic CMD_ENTER = 1'b0;
   localparam logic CMD_EXIT  = 1'b1;

   localparam logic ARCH_X86 = 1'b0;
   localparam logic ARCH_ARM = 1'b1;

   localparam logic CSR_ARCH_MODE      = 1'b0;
   localparam logic CSR_SLOW_THRESHOLD = 1'b1;

   localparam logic [DATA_W-1:0] SLOW_THRESHOLD_RST = 64'd1000000;

   // marks a slot that has no number in a table
   localparam logic [NR_W:0] NO_NUMBER = 11'h7FF;

   typedef struct packed {
      logic                command;
      logic [TIDX_W-1:0]   thread_index;
      logic [NR_W-1:0]     syscall_number;
      logic [DATA_W-1:0]   time_now;
      logic [GROUP_W-1:0]  group_id;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [SLOT_W-1:0]   slot_out;
      logic [GROUP_W-1:0]  group_out;
      logic [DATA_W-1:0]   duration;
      logic [DATA_W-1:0]   total_time;
      logic [DATA_W-1:0]   call_count;
      logic [DATA_W-1:0]   slow_calls;
      logic [DATA_W-1:0]   max_time;
   } rsp_type;

   typedef struct packed {
      logic clear_step;
      logic load_item;
      logic fold;
      logic index;
      logic thread_read;
      logic stat_read;
      logic finish;
   } ctrl_cmd_type;

   typedef struct packed {
      logic clear_done;
      logic is_exit;
   } ctrl_status_type;

   typedef struct packed {
      logic              hit;
      logic [SLOT_W-1:0] slot;
   } slot_hit_type;

   function automatic logic [NR_W:0] x86_number(input logic [SLOT_W-1:0] s);
      logic [NR_W:0] n;
      unique case (s)
         5'd0:    n = 11'd0;
         5'd1:    n = 11'd1;
         5'd2:    n = 11'd7;
         5'd3:    n = 11'd9;
         5'd4:    n = 11'd11;
         5'd5:    n = 11'd17;
         5'd6:    n = 11'd18;
         5'd7:    n = 11'd23;
         5'd8:    n = 11'd42;
         5'd9:    n = 11'd43;
         5'd10:   n = 11'd56;
         5'd11:   n = 11'd59;
         5'd12:   n = 11'd202;
         5'd13:   n = 11'd232;
         5'd14:   n = 11'd281;
         5'd15:   n = 11'd288;
         5'd16:   n = 11'd426;
         default: n = NO_NUMBER;
      endcase
      return n;
   endfunction

   function automatic logic [NR_W:0] arm_number(input logic [SLOT_W-1:0] s);
      logic [NR_W:0] n;
      unique case (s)
         5'd0:    n = 11'd63;
         5'd1:    n = 11'd64;
         5'd2:    n = 11'd73;
         5'd3:    n = 11'd222;
         5'd4:    n = 11'd215;
         5'd5:    n = 11'd67;
         5'd6:    n = 11'd68;
         5'd7:    n = 11'd72;
         5'd8:    n = 11'd203;
         5'd9:    n = 11'd202;
         5'd10:   n = 11'd220;
         5'd11:   n = 11'd221;
         5'd12:   n = 11'd98;
         5'd13:   n = 11'd22;
         5'd14:   n = NO_NUMBER;
         5'd15:   n = 11'd242;
         5'd16:   n = 11'd426;
         default: n = NO_NUMBER;
      endcase
      return n;
   endfunction

   // lowest slot whose number matches
   function automatic slot_hit_type slot_lookup(input logic arch, input logic [NR_W-1:0] nr);
      slot_hit_type  res;
      logic [NR_W:0] num;
      res = '0;
      for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
         num = (arch == ARCH_ARM) ? arm_number(SLOT_W'(i)) : x86_number(SLOT_W'(i));
         if (num == {1'b0, nr}) begin
            res.hit  = 1'b1;
            res.slot = SLOT_W'(i);
         end
      end
      return res;
   endfunction

endpackage

>>> rtl/slm_ctrl.sv
// sequencer for the syscall latency monitor: clearing pass, item steps, result handshake
module slm_ctrl import slm_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   input  ctrl_status_type status_i,
   output ctrl_cmd_type    cmd_o
);

   localparam logic [2:0] S_CLEAR  = 3'd0;
   localparam logic [2:0] S_IDLE   = 3'd1;
   localparam logic [2:0] S_FOLD   = 3'd2;
   localparam logic [2:0] S_INDEX  = 3'd3;
   localparam logic [2:0] S_TREAD  = 3'd4;
   localparam logic [2:0] S_SREAD  = 3'd5;
   localparam logic [2:0] S_FINISH = 3'd6;

   logic [2:0]   state_ff;
   logic [2:0]   state_in;
   logic         rsp_valid_ff;
   logic         rsp_valid_in;
   logic         out_free;
   ctrl_cmd_type cmd;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign cmd_o     = cmd;

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      unique case (state_ff)
         S_CLEAR: begin
            if (status_i.clear_done) begin
               state_in = S_IDLE;
            end else begin
               cmd.clear_step = 1'b1;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.load_item = 1'b1;
               state_in      = S_FOLD;
            end
         end
         S_FOLD: begin
            cmd.fold = 1'b1;
            state_in = S_INDEX;
         end
         S_INDEX: begin
            cmd.index = 1'b1;
            state_in  = status_i.is_exit ? S_TREAD : S_FINISH;
         end
         S_TREAD: begin
            cmd.thread_read = 1'b1;
            state_in        = S_SREAD;
         end
         S_SREAD: begin
            cmd.stat_read = 1'b1;
            state_in      = S_FINISH;
         end
         S_FINISH: begin
            if (out_free) begin
               cmd.finish   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

>>> rtl/slm_datapath.sv
// datapath: config registers, index folding, thread and statistics memories, result register
module slm_datapath import slm_pkg::*; #(
   parameter int THREAD_ENTRIES = THREAD_ENTRIES_DEF,
   parameter int GROUP_COUNT    = GROUP_COUNT_DEF
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            csr_write,
   input  logic            csr_index,
   input  logic [63:0]     csr_data,
   input  req_type         req_data,
   output rsp_type         rsp_data,
   input  ctrl_cmd_type    cmd_i,
   output ctrl_status_type status_o
);

   localparam int STAT_ENTRIES = GROUP_COUNT * SLOT_COUNT;
   localparam int CLEAR_DEPTH  = (THREAD_ENTRIES > STAT_ENTRIES) ? THREAD_ENTRIES : STAT_ENTRIES;
   localparam int TID_W        = $clog2(THREAD_ENTRIES);
   localparam int ST_W         = $clog2(STAT_ENTRIES);
   localparam int CLR_W        = $clog2(CLEAR_DEPTH + 1);

   // remainder by reciprocal multiply, at most one correction
   localparam int          TID_SHIFT = 28;
   localparam logic [24:0] TID_RECIP = 25'((2 ** TID_SHIFT) / THREAD_ENTRIES);
   localparam int          GRP_SHIFT = 16;
   localparam logic [16:0] GRP_RECIP = 17'((2 ** GRP_SHIFT) / GROUP_COUNT);

   typedef struct packed {
      logic                valid;
      logic [DATA_W-1:0]   start;
      logic [SLOT_W-1:0]   slot;
      logic [GROUP_W-1:0]  group;
   } thread_entry_type;

   typedef struct packed {
      logic [DATA_W-1:0] total;
      logic [DATA_W-1:0] count;
      logic [DATA_W-1:0] slow;
      logic [DATA_W-1:0] max;
   } stat_entry_type;

   thread_entry_type thread_mem [THREAD_ENTRIES];
   stat_entry_type   stat_mem   [STAT_ENTRIES];

   logic              arch_mode_ff;
   logic [63:0]       slow_threshold_ff;
   logic [CLR_W-1:0]  clear_cnt_ff;

   req_type           item_ff;
   logic [10:0]       q_tid_ff;
   logic [8:0]        q_grp_ff;
   slot_hit_type      lookup_ff;
   logic [TID_W-1:0]  tid_ff;
   logic [GROUP_W-1:0] grp_ff;
   thread_entry_type  thr_rd_ff;
   stat_entry_type    stat_rd_ff;
   logic [DATA_W-1:0] dur_ff;
   logic [ST_W-1:0]   stat_addr_ff;
   rsp_type           rsp_ff;

   logic [38:0]        tid_prod;
   logic [24:0]        grp_prod;
   logic [27:0]        tid_sub;
   logic [19:0]        grp_sub;
   logic [TIDX_W-1:0]  tid_rem;
   logic [GROUP_W-1:0] grp_rem;
   logic [TIDX_W-1:0]  tid_fold;
   logic [GROUP_W-1:0] grp_fold;
   logic [12:0]        stat_key;

   logic               clear_thread;
   logic               clear_stat;
   logic               thr_we;
   logic [TID_W-1:0]   thr_waddr;
   thread_entry_type   thr_wdata;
   logic               stat_we;
   logic [ST_W-1:0]    stat_waddr;
   stat_entry_type     stat_wdata;
   stat_entry_type     stat_new;
   rsp_type            rsp_in;

   assign status_o = '{clear_done: (clear_cnt_ff == CLR_W'(CLEAR_DEPTH)),
                       is_exit:    (item_ff.command == CMD_EXIT)};
   assign rsp_data = rsp_ff;

   // config registers
   always_ff @(posedge clock) begin
      if (reset) begin
         arch_mode_ff      <= ARCH_X86;
         slow_threshold_ff <= SLOW_THRESHOLD_RST;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_ARCH_MODE:      arch_mode_ff      <= csr_data[0];
            CSR_SLOW_THRESHOLD: slow_threshold_ff <= csr_data;
            default:            arch_mode_ff      <= arch_mode_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_cnt_ff <= '0;
      end else if (cmd_i.clear_step) begin
         clear_cnt_ff <= clear_cnt_ff + CLR_W'(1);
      end
   end

   // index folding
   assign tid_prod = 39'(item_ff.thread_index) * 39'(TID_RECIP);
   assign grp_prod = 25'(item_ff.group_id) * 25'(GRP_RECIP);
   assign tid_sub  = 28'(item_ff.thread_index) - 28'(q_tid_ff) * 28'(THREAD_ENTRIES);
   assign grp_sub  = 20'(item_ff.group_id) - 20'(q_grp_ff) * 20'(GROUP_COUNT);
   assign tid_rem  = tid_sub[TIDX_W-1:0];
   assign grp_rem  = grp_sub[GROUP_W-1:0];
   assign tid_fold = (18'(tid_rem) >= 18'(THREAD_ENTRIES)) ?
                     tid_rem - TIDX_W'(THREAD_ENTRIES) : tid_rem;
   assign grp_fold = (11'(grp_rem) >= 11'(GROUP_COUNT)) ?
                     grp_rem - GROUP_W'(GROUP_COUNT) : grp_rem;

   assign stat_key = 13'(thr_rd_ff.group) * 13'(SLOT_COUNT) + 13'(thr_rd_ff.slot);

   always_ff @(posedge clock) begin
      if (cmd_i.load_item) begin
         item_ff <= req_data;
      end
      if (cmd_i.fold) begin
         q_tid_ff  <= tid_prod[TID_SHIFT+10:TID_SHIFT];
         q_grp_ff  <= grp_prod[GRP_SHIFT+8:GRP_SHIFT];
         lookup_ff <= slot_lookup(arch_mode_ff, item_ff.syscall_number);
      end
      if (cmd_i.index) begin
         tid_ff <= TID_W'(tid_fold);
         grp_ff <= grp_fold;
      end
      if (cmd_i.stat_read) begin
         dur_ff       <= item_ff.time_now - thr_rd_ff.start;
         stat_addr_ff <= ST_W'(stat_key);
      end
      if (cmd_i.finish) begin
         rsp_ff <= rsp_in;
      end
   end

   // thread table
   assign clear_thread = cmd_i.clear_step && (clear_cnt_ff < CLR_W'(THREAD_ENTRIES));
   assign clear_stat   = cmd_i.clear_step && (clear_cnt_ff < CLR_W'(STAT_ENTRIES));

   always_comb begin
      thr_we    = 1'b0;
      thr_waddr = tid_ff;
      thr_wdata = '0;
      if (clear_thread) begin
         thr_we    = 1'b1;
         thr_waddr = clear_cnt_ff[TID_W-1:0];
      end else if (cmd_i.finish) begin
         if (item_ff.command == CMD_ENTER) begin
            thr_we          = lookup_ff.hit;
            thr_wdata.valid = 1'b1;
            thr_wdata.start = item_ff.time_now;
            thr_wdata.slot  = lookup_ff.slot;
            thr_wdata.group = grp_ff;
         end else begin
            thr_we = thr_rd_ff.valid;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (thr_we) begin
         thread_mem[thr_waddr] <= thr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd_i.thread_read) begin
         thr_rd_ff <= thread_mem[tid_ff];
      end
   end

   // statistics table
   always_comb begin
      stat_new.total = stat_rd_ff.total + dur_ff;
      stat_new.count = stat_rd_ff.count + 64'd1;
      stat_new.slow  = stat_rd_ff.slow + 64'(dur_ff > slow_threshold_ff);
      stat_new.max   = (stat_rd_ff.max < dur_ff) ? dur_ff : stat_rd_ff.max;
   end

   always_comb begin
      rsp_in = '0;
      if (item_ff.command == CMD_ENTER) begin
         if (lookup_ff.hit) begin
            rsp_in.status    = STATUS_STORED;
            rsp_in.slot_out  = lookup_ff.slot;
            rsp_in.group_out = grp_ff;
         end else begin
            rsp_in.status = STATUS_UNTRACKED;
         end
      end else if (!thr_rd_ff.valid) begin
         rsp_in.status = STATUS_NO_ENTRY;
      end else begin
         rsp_in.slot_out  = thr_rd_ff.slot;
         rsp_in.group_out = thr_rd_ff.group;
         if (dur_ff[DATA_W-1]) begin
            rsp_in.status = STATUS_NEGATIVE;
         end else begin
            rsp_in.status     = STATUS_UPDATED;
            rsp_in.duration   = dur_ff;
            rsp_in.total_time = stat_new.total;
            rsp_in.call_count = stat_new.count;
            rsp_in.slow_calls = stat_new.slow;
            rsp_in.max_time   = stat_new.max;
         end
      end
   end

   always_comb begin
      stat_we    = 1'b0;
      stat_waddr = stat_addr_ff;
      stat_wdata = stat_new;
      if (clear_stat) begin
         stat_we    = 1'b1;
         stat_waddr = clear_cnt_ff[ST_W-1:0];
         stat_wdata = '0;
      end else if (cmd_i.finish && (rsp_in.status == STATUS_UPDATED)) begin
         stat_we = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (stat_we) begin
         stat_mem[stat_waddr] <= stat_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd_i.stat_read) begin
         stat_rd_ff <= stat_mem[ST_W'(stat_key)];
      end
   end

endmodule

>>> rtl/syscall_latency_monitor.sv
// top level of the syscall latency monitor
//
//   channel  handshake              payload
//   req      req_valid / req_stall   req_data  (req_type)
//   rsp      rsp_valid / rsp_stall   rsp_data  (rsp_type)
//   csr      csr_valid / csr_ready   csr_index, csr_data
//
// an enter item's result follows its acceptance after the steps fold, index and finish,
// an exit item's after fold, index, thread table read, statistics read and update;
// the next item is accepted once the result is registered and the sequencer is idle, one in work
// after reset a clearing pass over max(THREAD_ENTRIES, 17 * GROUP_COUNT) entries
// (16384 by default) zeroes both tables; req_stall stays high meanwhile
// a result waits in the output register while the next item is accepted and worked;
// that item holds in its last step while rsp_stall keeps the previous one
module syscall_latency_monitor import slm_pkg::*; #(
   parameter int THREAD_ENTRIES = THREAD_ENTRIES_DEF,
   parameter int GROUP_COUNT    = GROUP_COUNT_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [63:0] csr_data
);

   ctrl_cmd_type    cmd;
   ctrl_status_type status;

   assign csr_ready = 1'b1;

   slm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status_i  (status),
      .cmd_o     (cmd)
   );

   slm_datapath #(
      .THREAD_ENTRIES (THREAD_ENTRIES),
      .GROUP_COUNT    (GROUP_COUNT)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_valid && csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .req_data  (req_data),
      .rsp_data  (rsp_data),
      .cmd_i     (cmd),
      .status_o  (status)
   );

endmodule
